// ===== design/sensor_frame_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame deframer.
// The macros expect signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_DEFRAMER_MACROS_SVH
`define SENSOR_FRAME_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the sensor frame deframer modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int FRAME_LEN_W = 7;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h7E;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h23;
    localparam int                RAW_LEN    = 23;
    localparam int                EULER_LEN  = 17;
    localparam int                MIN_LEN    = 5;

    // Bytes kept from a frame: the function byte and the word payload.
    localparam int STORE_LO      = 3;
    localparam int PAYLOAD_BYTES = 18;
    localparam int STORE_N       = PAYLOAD_BYTES + 1;
    localparam int NUM_WORDS     = 9;
    localparam int EULER_WORDS   = 6;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAW_CODE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EULER_CODE = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_RAW      = 3'd0,
        ST_EULER    = 3'd1,
        ST_OTHER    = 3'd2,
        ST_CSUM_ERR = 3'd3,
        ST_LEN_ERR  = 3'd4
    } status_t;

    typedef struct packed {
        status_t                                status;
        logic [BYTE_W-1:0]                      func;
        logic [FRAME_LEN_W-1:0]                 len;
        logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0]   payload;
    } event_t;

endpackage

// ===== design/sfd_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_byte_if
// Received byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/sfd_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_result_if
// Frame result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfd_result_if;
    logic                              valid;
    logic                              ready;
    logic [sfd_pkg::STATUS_W-1:0]      status;
    logic [sfd_pkg::BYTE_W-1:0]        function_code;
    logic [sfd_pkg::FRAME_LEN_W-1:0]   frame_length;
    logic signed [sfd_pkg::WORD_W-1:0] word0;
    logic signed [sfd_pkg::WORD_W-1:0] word1;
    logic signed [sfd_pkg::WORD_W-1:0] word2;
    logic signed [sfd_pkg::WORD_W-1:0] word3;
    logic signed [sfd_pkg::WORD_W-1:0] word4;
    logic signed [sfd_pkg::WORD_W-1:0] word5;
    logic signed [sfd_pkg::WORD_W-1:0] word6;
    logic signed [sfd_pkg::WORD_W-1:0] word7;
    logic signed [sfd_pkg::WORD_W-1:0] word8;

    modport source (
        output valid, output status, output function_code, output frame_length,
        output word0, output word1, output word2, output word3, output word4,
        output word5, output word6, output word7, output word8,
        input ready
    );
    modport sink (
        input valid, input status, input function_code, input frame_length,
        input word0, input word1, input word2, input word3, input word4,
        input word5, input word6, input word7, input word8,
        output ready
    );
endinterface

// ===== design/sfd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_front
// Byte parser: header hunt, length check, running sum and frame classification.
// ----------------------------------------------------------------------------
module sfd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    sfd_byte_if.sink                          rx,
    input  logic                              wr_en,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]    wr_data,
    output logic                              ev_valid,
    output sfd_pkg::event_t                   ev,
    input  logic                              ev_ready
);
    import sfd_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  explen_reg, explen_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] raw_code_reg, euler_code_reg;
    logic [BYTE_W-1:0] store_reg [STORE_N];

    logic              take;
    logic              store_we;
    logic [BYTE_W-1:0] b;
    logic [POS_W-1:0]  pos_inc;

    // A byte is taken only when the queue has room for a possible result.
    assign rx.ready = ev_ready;
    assign take     = rx.valid && rx.ready;
    assign b        = rx.rx_byte;
    assign pos_inc  = pos_reg + POS_W'(1);

    always_comb
    begin
        pos_next    = pos_reg;
        explen_next = explen_reg;
        sum_next    = sum_reg;
        store_we    = 1'b0;
        ev_valid    = 1'b0;
        ev.status   = ST_LEN_ERR;
        ev.func     = '0;
        ev.len      = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            ev.payload[i] = store_reg[i + 1];
        end

        if (take)
        begin
            case (pos_reg)
                POS_W'(0):
                begin
                    if (b == HDR_FIRST)
                    begin
                        sum_next = b;
                        pos_next = POS_W'(1);
                    end
                end
                POS_W'(1):
                begin
                    if (b == HDR_SECOND)
                    begin
                        sum_next = sum_reg + b;
                        pos_next = POS_W'(2);
                    end
                    else if (b == HDR_FIRST)
                    begin
                        sum_next = b;
                        pos_next = POS_W'(1);
                    end
                    else
                    begin
                        pos_next    = '0;
                        explen_next = '0;
                        sum_next    = '0;
                    end
                end
                POS_W'(2):
                begin
                    if (b < BYTE_W'(MIN_LEN) || b > BYTE_W'(MAX_FRAME_BYTES))
                    begin
                        pos_next    = '0;
                        explen_next = '0;
                        sum_next    = '0;
                        ev_valid    = 1'b1;
                    end
                    else
                    begin
                        explen_next = POS_W'(b);
                        sum_next    = sum_reg + b;
                        pos_next    = POS_W'(3);
                    end
                end
                default:
                begin
                    if (pos_reg >= POS_W'(MAX_FRAME_BYTES))
                    begin
                        // Overflow guard: reported like a bad length.
                        pos_next    = '0;
                        explen_next = '0;
                        sum_next    = '0;
                        ev_valid    = 1'b1;
                    end
                    else
                    begin
                        store_we = 1'b1;
                        pos_next = pos_inc;
                        if (pos_inc != explen_reg)
                        begin
                            sum_next = sum_reg + b;
                        end
                        else
                        begin
                            // Last byte of the frame: it carries the checksum.
                            pos_next    = '0;
                            explen_next = '0;
                            sum_next    = '0;
                            ev_valid    = 1'b1;
                            ev.len      = FRAME_LEN_W'(explen_reg);
                            if (sum_reg != b)
                            begin
                                ev.status = ST_CSUM_ERR;
                            end
                            else
                            begin
                                ev.func = store_reg[0];
                                if (store_reg[0] == raw_code_reg &&
                                    explen_reg == POS_W'(RAW_LEN))
                                begin
                                    ev.status = ST_RAW;
                                end
                                else if (store_reg[0] == euler_code_reg &&
                                         explen_reg == POS_W'(EULER_LEN))
                                begin
                                    ev.status = ST_EULER;
                                end
                                else
                                begin
                                    ev.status = ST_OTHER;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            explen_reg     <= '0;
            sum_reg        <= '0;
            raw_code_reg   <= 8'd1;
            euler_code_reg <= 8'd2;
        end
        else
        begin
            pos_reg    <= pos_next;
            explen_reg <= explen_next;
            sum_reg    <= sum_next;
            if (wr_en && wr_index == CFG_RAW_CODE)
            begin
                raw_code_reg <= wr_data;
            end
            if (wr_en && wr_index == CFG_EULER_CODE)
            begin
                euler_code_reg <= wr_data;
            end
        end
    end

    // Only the function byte and the word payload are ever read back.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_N; i++)
        begin
            if (store_we && pos_reg == POS_W'(STORE_LO + i))
            begin
                store_reg[i] <= b;
            end
        end
    end

endmodule

// ===== design/sfd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_queue
// Short FIFO of classified frame events between the parser and the output.
// ----------------------------------------------------------------------------
`include "sensor_frame_deframer_macros.svh"

module sfd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  sfd_pkg::event_t push_data,
    output logic            push_ready,
    output logic            pop_valid,
    output sfd_pkg::event_t pop_data,
    input  logic            pop_ready
);
    import sfd_pkg::*;

    event_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SFD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue over depth")
    `SFD_ASSERT_NXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1), "push lost")
    `SFD_ASSERT_NXT(a_pop_shrinks, pop && !push, count_reg == $past(count_reg) - QCNT_W'(1), "pop lost")

endmodule

// ===== design/sfd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_back
// Output stage: unpacks frame words by status and holds the result register.
// ----------------------------------------------------------------------------
module sfd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ev_valid,
    input  sfd_pkg::event_t ev,
    output logic            ev_ready,
    sfd_result_if.source    res
);
    import sfd_pkg::*;

    logic                           valid_reg;
    logic [STATUS_W-1:0]            status_reg;
    logic [BYTE_W-1:0]              func_reg;
    logic [FRAME_LEN_W-1:0]         len_reg;
    logic signed [WORD_W-1:0]       word_reg [NUM_WORDS];
    logic signed [WORD_W-1:0]       word_next [NUM_WORDS];
    logic                           load;

    assign ev_ready = !valid_reg || res.ready;
    assign load     = ev_valid && ev_ready;

    // Words are little-endian byte pairs; an Euler frame fills the first six.
    always_comb
    begin
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            if (ev.status == ST_RAW || (ev.status == ST_EULER && k < EULER_WORDS))
            begin
                word_next[k] = {ev.payload[2 * k + 1], ev.payload[2 * k]};
            end
            else
            begin
                word_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= ev.status;
            func_reg   <= ev.func;
            len_reg    <= ev.len;
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                word_reg[k] <= word_next[k];
            end
        end
    end

    assign res.valid         = valid_reg;
    assign res.status        = status_reg;
    assign res.function_code = func_reg;
    assign res.frame_length  = len_reg;
    assign res.word0         = word_reg[0];
    assign res.word1         = word_reg[1];
    assign res.word2         = word_reg[2];
    assign res.word3         = word_reg[3];
    assign res.word4         = word_reg[4];
    assign res.word5         = word_reg[5];
    assign res.word6         = word_reg[6];
    assign res.word7         = word_reg[7];
    assign res.word8         = word_reg[8];

endmodule

// ===== design/sensor_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_deframer
// Byte-serial frame receiver with header hunt, length and checksum checks.
// ----------------------------------------------------------------------------
// Bytes enter on the rx channel, one transfer per byte. Frames have the form
// 0x7E 0x23 LEN FUNC payload SUM, where SUM is the 8-bit sum of all bytes
// before it. Each finished frame, bad checksum or bad length byte produces one
// transfer on the res channel; all other bytes produce nothing.
// The rx channel takes one byte every cycle while rx.ready is high. The parser
// pushes results into a two-entry queue that feeds the output register behind
// res; rx.ready drops only when that queue is full, which happens only while
// the receiver of res holds ready low. Stalls never drop results. The function
// codes for raw and Euler frames are written through wr_en, wr_index and
// wr_data (index 0 raw, index 1 Euler); the user must write them only while
// the block is idle, which the block itself does not enforce. Reset returns
// the parser to header hunting, empties the queue, clears the output valid
// and sets the function codes to 1 and 2.
// ----------------------------------------------------------------------------
module sensor_frame_deframer (
    input  logic                            clk,
    input  logic                            rst_n,
    sfd_byte_if.sink                        rx,
    sfd_result_if.source                    res,
    input  logic                            wr_en,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]  wr_data
);
    import sfd_pkg::*;

    logic   front_valid, front_ready;
    event_t front_ev;
    logic   back_valid, back_ready;
    event_t back_ev;

    sfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .ev_valid (front_valid),
        .ev       (front_ev),
        .ev_ready (front_ready)
    );

    sfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_data  (front_ev),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_data   (back_ev),
        .pop_ready  (back_ready)
    );

    sfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (back_valid),
        .ev       (back_ev),
        .ev_ready (back_ready),
        .res      (res)
    );

endmodule
